FILE: rtl/core/cst_pkg.sv
`timescale 1ns / 1ps
// cst_pkg: shared types, codes and constants for the CSV stream tokenizer.
// No dependencies; imported by every module in rtl/core.
package cst_pkg;

    // Input item kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    // Result event codes
    localparam logic [1:0] EV_BYTE = 2'd0;
    localparam logic [1:0] EV_CELL = 2'd1;
    localparam logic [1:0] EV_ROW  = 2'd2;
    localparam logic [1:0] EV_SUM  = 2'd3;

    // Operation codes passed from front to back
    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_CELL = 2'd1;
    localparam logic [1:0] OP_ROW  = 2'd2;
    localparam logic [1:0] OP_EOS  = 2'd3;

    // Delimiter characters
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Defaults for the top-level parameters
    localparam int unsigned DEF_MAX_COLUMNS = 1024;
    localparam int unsigned DEF_MAX_ROWS    = 65535;

    // Depth of the operation queue between front and back (power of two)
    localparam int unsigned OPQ_DEPTH = 4;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  cell_byte;
        logic [10:0] column_index;
        logic [15:0] row_index;
        logic [10:0] max_columns;
        logic        ragged;
        logic        last;
    } t_res_item;

    typedef struct packed {
        logic [1:0] code;
        logic [7:0] data;
    } t_op;

endpackage

FILE: rtl/core/cst_front.sv
`timescale 1ns / 1ps
// cst_front: accepts input items and classifies bytes against the quote state.
// Depends on cst_pkg; pushes operations into cst_fifo.
module cst_front
    import cst_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_full,
    output logic     o_push,
    output t_op      o_op
);

    logic r_inq, r_qs, r_skip;
    logic n_inq, n_qs, n_skip;
    logic accept;
    logic gen;
    t_op  op;
    logic inq_eff;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        n_inq   = r_inq;
        n_qs    = r_qs;
        n_skip  = r_skip;
        gen     = 1'b0;
        op.code = OP_BYTE;
        op.data = i_item.byte_value;
        inq_eff = r_inq;
        if (i_item.kind == KIND_EOS) begin
            gen     = 1'b1;
            op.code = OP_EOS;
            n_inq   = 1'b0;
            n_qs    = 1'b0;
            n_skip  = 1'b0;
        end else if (r_skip && i_item.byte_value == CH_LF) begin
            // LF of a CRLF pair: swallowed
            n_skip = 1'b0;
        end else begin
            n_skip = 1'b0;
            if (r_qs && i_item.byte_value == CH_QUOTE) begin
                // doubled quote: literal quote byte, still quoted
                n_qs    = 1'b0;
                gen     = 1'b1;
                op.code = OP_BYTE;
            end else begin
                if (r_qs) begin
                    n_qs    = 1'b0;
                    inq_eff = 1'b0;
                    n_inq   = 1'b0;
                end
                if (inq_eff) begin
                    if (i_item.byte_value == CH_QUOTE) begin
                        n_qs = 1'b1;
                    end else begin
                        gen     = 1'b1;
                        op.code = OP_BYTE;
                    end
                end else begin
                    case (i_item.byte_value)
                        CH_QUOTE: begin
                            n_inq = 1'b1;
                        end
                        CH_COMMA: begin
                            gen     = 1'b1;
                            op.code = OP_CELL;
                        end
                        CH_CR: begin
                            gen     = 1'b1;
                            op.code = OP_ROW;
                            n_skip  = 1'b1;
                        end
                        CH_LF: begin
                            gen     = 1'b1;
                            op.code = OP_ROW;
                        end
                        default: begin
                            gen     = 1'b1;
                            op.code = OP_BYTE;
                        end
                    endcase
                end
            end
        end
    end

    assign o_push = accept && gen;
    assign o_op   = op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inq  <= 1'b0;
            r_qs   <= 1'b0;
            r_skip <= 1'b0;
        end else if (accept) begin
            r_inq  <= n_inq;
            r_qs   <= n_qs;
            r_skip <= n_skip;
        end
    end

endmodule

FILE: rtl/core/cst_fifo.sv
`timescale 1ns / 1ps
// cst_fifo: short operation queue between the front and back parts.
// Depends on cst_pkg for t_op and OPQ_DEPTH.
module cst_fifo
    import cst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    output logic o_valid,
    output t_op  o_op,
    input  logic i_pop
);

    localparam int unsigned PTR_W = $clog2(OPQ_DEPTH);
    localparam int unsigned CNT_W = $clog2(OPQ_DEPTH + 1);

    t_op              r_mem [OPQ_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(OPQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("op queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("op queue read while empty");

endmodule

FILE: rtl/core/cst_back.sv
`timescale 1ns / 1ps
// cst_back: carries out queued operations, keeps row and column counts and
// width metrics, and drives the registered result item. Depends on cst_pkg.
module cst_back
    import cst_pkg::*;
#(
    parameter int unsigned MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int unsigned MAX_ROWS    = DEF_MAX_ROWS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_header,
    input  logic      i_op_valid,
    input  t_op       i_op,
    output logic      o_pop,
    output logic      o_res_valid,
    input  logic      i_res_ready,
    output t_res_item o_res_item
);

    localparam int unsigned COL_W = $clog2(MAX_COLUMNS + 1);
    localparam int unsigned ROW_W = $clog2(64'(MAX_ROWS) + 64'd1);
    localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_COLUMNS);
    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(MAX_ROWS);

    logic [COL_W-1:0] r_cells, n_cells;
    logic [ROW_W-1:0] r_rows, n_rows;
    logic [COL_W-1:0] r_first, n_first;
    logic [COL_W-1:0] r_widest, n_widest;
    logic             r_mis, n_mis;
    logic             r_ref, n_ref;
    logic             r_has, n_has;
    logic             r_eos_pend, n_eos_pend;
    logic             r_out_valid, n_out_valid;
    t_res_item        r_out, n_out;

    logic             load_ok;
    logic [COL_W-1:0] row_w;
    logic             counted;
    logic [COL_W-1:0] row_widest, row_first;
    logic             row_mis;
    logic [ROW_W-1:0] rows_inc;

    function automatic t_res_item mk_res(
        input logic [1:0]       ev,
        input logic [7:0]       b,
        input logic [COL_W-1:0] col,
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] wmax,
        input logic             rag,
        input logic             lst
    );
        t_res_item r;
        r.event_res    = ev;
        r.cell_byte    = b;
        r.column_index = 11'(col);
        r.row_index    = 16'(row);
        r.max_columns  = 11'(wmax);
        r.ragged       = rag;
        r.last         = lst;
        return r;
    endfunction

    // Row-end metrics, worked out from the current state
    always_comb begin
        row_w      = (r_cells == COL_MAX) ? r_cells : r_cells + 1'b1;
        counted    = !(i_header && r_rows == '0);
        row_widest = r_widest;
        row_first  = r_first;
        row_mis    = r_mis;
        if (counted) begin
            if (row_w > r_widest) begin
                row_widest = row_w;
            end
            if (!r_ref) begin
                row_first = row_w;
            end else if (row_w != r_first) begin
                row_mis = 1'b1;
            end
        end
        rows_inc = (r_rows < ROW_MAX) ? r_rows + 1'b1 : r_rows;
    end

    always_comb begin
        load_ok     = !r_out_valid || i_res_ready;
        o_pop       = i_op_valid && load_ok && !r_eos_pend;
        n_cells     = r_cells;
        n_rows      = r_rows;
        n_first     = r_first;
        n_widest    = r_widest;
        n_mis       = r_mis;
        n_ref       = r_ref;
        n_has       = r_has;
        n_eos_pend  = r_eos_pend;
        n_out_valid = r_out_valid && !i_res_ready;
        n_out       = r_out;

        if (r_eos_pend && load_ok) begin
            // summary after a flushed row, then back to a fresh stream
            n_out_valid = 1'b1;
            n_out       = mk_res(EV_SUM, 8'd0, '0, r_rows, r_widest, r_mis, 1'b1);
            n_eos_pend  = 1'b0;
            n_cells     = '0;
            n_rows      = '0;
            n_first     = '0;
            n_widest    = '0;
            n_mis       = 1'b0;
            n_ref       = 1'b0;
            n_has       = 1'b0;
        end else if (o_pop) begin
            n_out_valid = 1'b1;
            case (i_op.code)
                OP_BYTE: begin
                    n_out = mk_res(EV_BYTE, i_op.data, r_cells, r_rows, r_widest,
                                   r_mis, 1'b1);
                    n_has = 1'b1;
                end
                OP_CELL: begin
                    n_out   = mk_res(EV_CELL, 8'd0, r_cells, r_rows, r_widest,
                                     r_mis, 1'b1);
                    n_cells = (r_cells < COL_MAX) ? r_cells + 1'b1 : r_cells;
                    n_has   = 1'b0;
                end
                OP_ROW: begin
                    n_out    = mk_res(EV_ROW, 8'd0, row_w, r_rows, row_widest,
                                      row_mis, 1'b1);
                    n_widest = row_widest;
                    n_first  = row_first;
                    n_mis    = row_mis;
                    n_ref    = r_ref || counted;
                    n_rows   = rows_inc;
                    n_cells  = '0;
                    n_has    = 1'b0;
                end
                OP_EOS: begin
                    if (r_has || r_cells != '0) begin
                        // flush the open row now, summary once the output register can be reloaded
                        n_out      = mk_res(EV_ROW, 8'd0, row_w, r_rows, row_widest,
                                            row_mis, 1'b0);
                        n_widest   = row_widest;
                        n_first    = row_first;
                        n_mis      = row_mis;
                        n_ref      = r_ref || counted;
                        n_rows     = rows_inc;
                        n_cells    = '0;
                        n_has      = 1'b0;
                        n_eos_pend = 1'b1;
                    end else begin
                        n_out    = mk_res(EV_SUM, 8'd0, '0, r_rows, r_widest, r_mis,
                                          1'b1);
                        n_cells  = '0;
                        n_rows   = '0;
                        n_first  = '0;
                        n_widest = '0;
                        n_mis    = 1'b0;
                        n_ref    = 1'b0;
                        n_has    = 1'b0;
                    end
                end
                default: begin
                    n_out = r_out;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells     <= '0;
            r_rows      <= '0;
            r_first     <= '0;
            r_widest    <= '0;
            r_mis       <= 1'b0;
            r_ref       <= 1'b0;
            r_has       <= 1'b0;
            r_eos_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cells     <= n_cells;
            r_rows      <= n_rows;
            r_first     <= n_first;
            r_widest    <= n_widest;
            r_mis       <= n_mis;
            r_ref       <= n_ref;
            r_has       <= n_has;
            r_eos_pend  <= n_eos_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res_valid = r_out_valid;
    assign o_res_item  = r_out;

    a_pend_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_eos_pend |-> r_out_valid)
        else $error("summary pending without a flushed row in the output");
    a_sum_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_res == EV_SUM) |-> r_out.last)
        else $error("summary not marked last");
    a_cells_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cells <= COL_MAX)
        else $error("cell count beyond saturation limit");
    a_no_pop_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_eos_pend |-> !o_pop)
        else $error("op taken while summary pending");

endmodule

FILE: rtl/core/csv_stream_tokenizer.sv
`timescale 1ns / 1ps
// csv_stream_tokenizer: streaming RFC 4180 style CSV tokenizer.
// Path: an input item is registered in the op queue, then in the output register.
// Throughput: 1 item per cycle while the op queue has room; an end-of-stream item
// that flushes an open row gives a row end, then a summary, in the back part.
// Reset: i_rst_n synchronous, active low; clears quote state, counts, metrics,
// the op queue and the header_first_row register.
//
// Depends on cst_pkg, cst_front, cst_fifo and cst_back.
module csv_stream_tokenizer
    import cst_pkg::*;
#(
    parameter int unsigned MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int unsigned MAX_ROWS    = DEF_MAX_ROWS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input items: data bytes and end-of-stream markers
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    // result items
    output logic      o_res_valid,
    input  logic      i_res_ready,
    output t_res_item o_res_item,
    // configuration: header_first_row
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data
);

    // Header row register. The user must write it only while the block is idle
    // (the block does not enforce this), so the back part can read it directly.
    logic r_header;

    // front -> queue -> back
    logic q_push, q_full, q_valid, q_pop;
    t_op  q_in_op, q_out_op;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= 1'b0;
        end else if (i_cfg_valid) begin
            r_header <= i_cfg_data;
        end
    end

    // Front: quote, doubled-quote and CRLF tracking. One item per cycle
    // whenever the queue has room; bytes that make no event push nothing.
    cst_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_op    (q_in_op)
    );

    // Short queue so a stalled consumer does not stall the byte stream at once.
    cst_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (q_out_op),
        .i_pop   (q_pop)
    );

    // Back: cell/row counts, width metrics and the output register. The
    // output register is reloaded in the same cycle it is emptied.
    cst_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_header    (r_header),
        .i_op_valid  (q_valid),
        .i_op        (q_out_op),
        .o_pop       (q_pop),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res_item  (o_res_item)
    );

endmodule
